[hw/rtl/mpp_pkg.sv]
// ----------------------------------------------------------------------------
// mpp_pkg: shared types and constants for the modular power unit
// Holds the prime, the Barrett constant, the operation tags of the shared
// multiplier, the sequencer states and the structs between the modules.
// ----------------------------------------------------------------------------
package mpp_pkg;

  // The prime modulus 1000000007 and its multiples used in the final correction.
  localparam logic [29:0] P_PRIME = 30'd1000000007;
  localparam logic [31:0] P_PRIME_W = 32'd1000000007;
  localparam logic [31:0] P_TWICE = 32'd2000000014;

  // Barrett constant floor(2^60 / P_PRIME).
  localparam logic [30:0] BARRETT_MU = 31'd1152921496;

  // Operation carried alongside each multiplication through the pipeline.
  typedef enum logic [1:0] {
    OP_RED,
    OP_ACC,
    OP_SQR
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_RED_WAIT,
    S_ACC,
    S_SQR,
    S_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic        vld;
    op_t         op;
    logic [31:0] a;
    logic [29:0] b;
  } mm_req_t;

  typedef struct packed {
    logic        vld;
    op_t         op;
    logic [29:0] res;
  } mm_rsp_t;

  typedef struct packed {
    logic        vld;
    logic [29:0] power;
  } done_t;

endpackage

[hw/rtl/mpp_mulmod.sv]
// ----------------------------------------------------------------------------
// mpp_mulmod: pipelined modular multiplier
// Computes a * b mod P_PRIME with Barrett reduction in five register stages.
// The product must stay below 2^60.
// ----------------------------------------------------------------------------
module mpp_mulmod (
  input  logic             clk,
  input  logic             rst_n,
  input  mpp_pkg::mm_req_t req,
  output mpp_pkg::mm_rsp_t rsp
);

  logic [4:0]       vld_r;
  mpp_pkg::op_t     op_r [5];

  logic [59:0]      prod_r;
  logic [30:0]      q_r;
  logic [31:0]      xlo2_r;
  logic [31:0]      xlo3_r;
  logic [31:0]      qp_r;
  logic [31:0]      rem_r;
  logic [29:0]      res_r;

  logic [61:0]      prod_full;
  logic [61:0]      q_full;
  logic [60:0]      qp_full;
  logic [31:0]      rem_fix;

  assign prod_full = 62'(req.a) * 62'(req.b);
  assign q_full    = 62'(prod_r[59:29]) * 62'(mpp_pkg::BARRETT_MU);
  assign qp_full   = 61'(q_r) * 61'(mpp_pkg::P_PRIME);

  // The Barrett estimate leaves a remainder below three times the prime.
  always_comb begin
    if (rem_r >= mpp_pkg::P_TWICE) begin
      rem_fix = rem_r - mpp_pkg::P_TWICE;
    end else if (rem_r >= mpp_pkg::P_PRIME_W) begin
      rem_fix = rem_r - mpp_pkg::P_PRIME_W;
    end else begin
      rem_fix = rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[3:0], req.vld};
    end
  end

  always_ff @(posedge clk) begin
    op_r[0] <= req.op;
    op_r[1] <= op_r[0];
    op_r[2] <= op_r[1];
    op_r[3] <= op_r[2];
    op_r[4] <= op_r[3];
    prod_r  <= prod_full[59:0];
    q_r     <= q_full[61:31];
    xlo2_r  <= prod_r[31:0];
    qp_r    <= qp_full[31:0];
    xlo3_r  <= xlo2_r;
    rem_r   <= xlo3_r - qp_r;
    res_r   <= rem_fix[29:0];
  end

  assign rsp.vld = vld_r[4];
  assign rsp.op  = op_r[4];
  assign rsp.res = res_r;

endmodule

[hw/rtl/mpp_seq.sv]
// ----------------------------------------------------------------------------
// mpp_seq: square-and-multiply sequencer
// Holds the running power and product, walks the exponent from its low bit
// and issues multiplications to the shared modular multiplier.
// ----------------------------------------------------------------------------
module mpp_seq #(
  parameter int SCAN_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_rdy,
  input  logic [31:0]      in_base,
  input  logic [31:0]      in_exponent,
  input  logic             out_free,
  output mpp_pkg::done_t   done,
  output mpp_pkg::mm_req_t req,
  input  mpp_pkg::mm_rsp_t rsp
);

  mpp_pkg::state_t        state_r;
  mpp_pkg::state_t        state_nxt;

  logic [31:0]            base_r;
  logic [31:0]            base_nxt;
  logic [SCAN_BITS-1:0]   exp_r;
  logic [SCAN_BITS-1:0]   exp_nxt;
  logic [SCAN_BITS-1:0]   exp_shift;
  logic [29:0]            acc_r;
  logic [29:0]            acc_nxt;
  logic [29:0]            sq_r;
  logic [29:0]            sq_nxt;

  logic                   accept;
  logic                   red_done;
  logic                   acc_done;
  logic                   sqr_done;

  assign accept    = in_vld && in_rdy;
  assign red_done  = rsp.vld && (rsp.op == mpp_pkg::OP_RED);
  assign acc_done  = rsp.vld && (rsp.op == mpp_pkg::OP_ACC);
  assign sqr_done  = rsp.vld && (rsp.op == mpp_pkg::OP_SQR);
  assign exp_shift = exp_r >> 1;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpp_pkg::S_IDLE: begin
        if (in_vld) begin
          state_nxt = mpp_pkg::S_RED;
        end
      end
      mpp_pkg::S_RED: begin
        state_nxt = mpp_pkg::S_RED_WAIT;
      end
      mpp_pkg::S_RED_WAIT: begin
        if (red_done) begin
          if (exp_r == '0) begin
            state_nxt = mpp_pkg::S_DONE;
          end else if (exp_r[0]) begin
            state_nxt = mpp_pkg::S_ACC;
          end else begin
            state_nxt = mpp_pkg::S_SQR;
          end
        end
      end
      mpp_pkg::S_ACC: begin
        state_nxt = mpp_pkg::S_SQR;
      end
      mpp_pkg::S_SQR: begin
        state_nxt = mpp_pkg::S_WAIT;
      end
      mpp_pkg::S_WAIT: begin
        // Stop as soon as no set bit is left; later rounds cannot change the product.
        if (sqr_done) begin
          if (exp_shift == '0) begin
            state_nxt = mpp_pkg::S_DONE;
          end else if (exp_shift[0]) begin
            state_nxt = mpp_pkg::S_ACC;
          end else begin
            state_nxt = mpp_pkg::S_SQR;
          end
        end
      end
      mpp_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = mpp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mpp_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_rdy     = 1'b0;
    req.vld    = 1'b0;
    req.op     = mpp_pkg::OP_RED;
    req.a      = base_r;
    req.b      = 30'd1;
    done.vld   = 1'b0;
    done.power = acc_r;
    case (state_r)
      mpp_pkg::S_IDLE: begin
        in_rdy = 1'b1;
      end
      mpp_pkg::S_RED: begin
        req.vld = 1'b1;
      end
      mpp_pkg::S_ACC: begin
        req.vld = 1'b1;
        req.op  = mpp_pkg::OP_ACC;
        req.a   = {2'b00, acc_r};
        req.b   = sq_r;
      end
      mpp_pkg::S_SQR: begin
        req.vld = 1'b1;
        req.op  = mpp_pkg::OP_SQR;
        req.a   = {2'b00, sq_r};
        req.b   = sq_r;
      end
      mpp_pkg::S_DONE: begin
        done.vld = 1'b1;
      end
      default: begin
        in_rdy = 1'b0;
      end
    endcase
  end

  always_comb begin
    base_nxt = accept ? in_base : base_r;

    exp_nxt = exp_r;
    if (accept) begin
      exp_nxt = in_exponent[SCAN_BITS-1:0];
    end else if (sqr_done) begin
      exp_nxt = exp_shift;
    end

    sq_nxt = sq_r;
    if (red_done || sqr_done) begin
      sq_nxt = rsp.res;
    end

    acc_nxt = acc_r;
    if (red_done) begin
      acc_nxt = 30'd1;
    end else if (acc_done) begin
      acc_nxt = rsp.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpp_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    exp_r  <= exp_nxt;
    sq_r   <= sq_nxt;
    acc_r  <= acc_nxt;
  end

endmodule

[hw/rtl/mod_prime_pow_unit.sv]
// ----------------------------------------------------------------------------
// mod_prime_pow_unit: modular power modulo 1000000007
// Returns base to the exponent modulo the prime by square-and-multiply on
// one shared pipelined modular multiplier.
// ----------------------------------------------------------------------------
// The input channel takes one word holding a base and an exponent. The
// result channel gives one word holding the power, always below the prime.
// Every input word yields exactly one result word, in order.
// The base is first reduced through the multiplier, then each exponent bit
// from the lowest one costs a square, plus a multiply into the product when
// the bit is set. Scanning stops after the highest set bit.
// Each multiplication passes through the multiplier pipeline, and a round
// waits for its square to return; a round with a set bit issues its multiply
// into the product before the square. The time a word occupies the block
// grows with the position of the highest set exponent bit and with the number
// of set bits, so an all-ones exponent takes the longest while the receiver
// does not stall.
// The block takes one word at a time: in_tready is high only while it idles.
// A finished result waits in an output register, and a new word is taken while
// it waits. If the receiver still stalls when the next result is ready, the
// sequencer holds that result until the register frees up.
// Reset clears the sequencer state, the multiplier valid bits and the output valid bit.
// ----------------------------------------------------------------------------
module mod_prime_pow_unit #(
  parameter int EXP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] base, [63:32] exponent
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [29:0] power, [31:30] zero
);

  // Exponent bits that are scanned; bits above the field are ignored.
  localparam int SCAN_BITS = (EXP_BITS < 32) ? EXP_BITS : 32;

  mpp_pkg::mm_req_t mm_req;
  mpp_pkg::mm_rsp_t mm_rsp;
  mpp_pkg::done_t   done;

  logic             out_vld_r;
  logic [29:0]      out_power_r;
  logic             out_free;
  logic             out_load;

  // The output register can take a result when empty or when emptied this cycle.
  assign out_free = !out_vld_r || out_tready;
  assign out_load = done.vld && out_free;

  mpp_seq #(
    .SCAN_BITS(SCAN_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (in_tvalid),
    .in_rdy     (in_tready),
    .in_base    (in_tdata[31:0]),
    .in_exponent(in_tdata[63:32]),
    .out_free   (out_free),
    .done       (done),
    .req        (mm_req),
    .rsp        (mm_rsp)
  );

  mpp_mulmod u_mulmod (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mm_req),
    .rsp  (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_power_r <= done.power;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_power_r};

  // A delivered power is always fully reduced.
  a_power_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:0] < mpp_pkg::P_PRIME))
    else $error("power not reduced below the prime");

  // Once a word is taken, the block is busy in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("block ready again right after taking a word");

  // The multiplier only answers while a word is being worked on.
  a_rsp_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.vld |-> !in_tready)
    else $error("multiplier response while idle");

  // A result leaves the sequencer only into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_tready && done.vld) |=> done.vld)
    else $error("result dropped while output stalled");

endmodule
